@@ rtl/core/phpc_pkg.sv @@
// Shared package for the frame header parser: word types, byte-command record,
// protocol constants and the ones'-complement fold helpers.
// Used by every module in rtl/core; depends on nothing.
package phpc_pkg;

   // Frame bytes past this count are ignored and not counted.
   localparam int MAX_FRAME_BYTES = 2048;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
   // Wide enough for a byte count against header plus segment length.
   localparam int CMP_W           = 18;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [3:0]  IHL_MIN       = 4'd5;
   localparam logic [15:0] SUM_ALL_ONES  = 16'hFFFF;

   localparam logic [1:0] FRAME_UNKNOWN = 2'd0;
   localparam logic [1:0] FRAME_IPV4    = 2'd1;
   localparam logic [1:0] FRAME_ARP     = 2'd2;

   localparam logic [1:0] L4_NONE = 2'd0;
   localparam logic [1:0] L4_ICMP = 2'd1;
   localparam logic [1:0] L4_UDP  = 2'd2;
   localparam logic [1:0] L4_TCP  = 2'd3;

   // Byte offsets within the frame.
   localparam logic [POS_W-1:0] POS_ETH_TYPE_HI  = POS_W'(12);
   localparam logic [POS_W-1:0] POS_ETH_TYPE_LO  = POS_W'(13);
   localparam logic [POS_W-1:0] POS_IP_START     = POS_W'(14);
   localparam logic [POS_W-1:0] POS_TLEN_HI      = POS_W'(16);
   localparam logic [POS_W-1:0] POS_TLEN_LO      = POS_W'(17);
   localparam logic [POS_W-1:0] POS_ARP_OP_HI    = POS_W'(20);
   localparam logic [POS_W-1:0] POS_ARP_OP_LO    = POS_W'(21);
   localparam logic [POS_W-1:0] POS_TTL          = POS_W'(22);
   localparam logic [POS_W-1:0] POS_PROTO        = POS_W'(23);
   localparam logic [POS_W-1:0] POS_PSEUDO_FIRST = POS_W'(26);
   localparam logic [POS_W-1:0] POS_PSEUDO_LAST  = POS_W'(33);
   // Offsets within the layer-4 header.
   localparam logic [POS_W-1:0] L4_OFF_SRC_LO    = POS_W'(1);
   localparam logic [POS_W-1:0] L4_OFF_DST_HI    = POS_W'(2);
   localparam logic [POS_W-1:0] L4_OFF_DST_LO    = POS_W'(3);
   localparam logic [POS_W-1:0] L4_OFF_FLAGS     = POS_W'(13);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [1:0]  l4_kind;
      logic [5:0]  ip_header_bytes;
      logic [15:0] ip_pdu_length;
      logic [7:0]  time_to_live;
      logic        ip_checksum_ok;
      logic        tcp_checksum_ok;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [3:0]  tcp_flag_bits;
      logic [15:0] type_code;
   } rsp_type;

   // What the back end does with one byte.
   typedef struct packed {
      logic hdr_add;
      logic pseudo_add;
      logic seg_add;
      logic cap_ttl;
      logic cap_proto;
      logic cap_type;
      logic cap_src;
      logic cap_dst;
      logic cap_flags;
      logic cap_arp;
   } byte_op_type;

   // One classified byte; the frame summary fields matter only on the last byte.
   typedef struct packed {
      logic [7:0]  data;
      logic        odd;
      byte_op_type op;
      logic        last;
      logic [1:0]  frame_kind;
      logic [3:0]  ihl;
      logic [15:0] total_length;
      logic [15:0] seg_len;
      logic        ip_len_ok;
      logic        seg_len_ok;
   } cmd_type;

   // Snapshot of a finished frame, ready for result formatting.
   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [3:0]  ihl;
      logic [15:0] total_length;
      logic [15:0] seg_len;
      logic        ip_len_ok;
      logic        seg_len_ok;
      logic [15:0] hdr_sum;
      logic [15:0] seg_sum;
      logic [7:0]  ttl;
      logic [7:0]  proto;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [3:0]  flags;
      logic [15:0] type_code;
   } fin_type;

   // End-around-carry fold of a 17-bit sum to 16 bits.
   function automatic logic [15:0] fold17(input logic [16:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {16'b0, s[16]};
      return t[15:0] + {15'b0, t[16]};
   endfunction

   // End-around-carry fold of an 18-bit sum to 16 bits.
   function automatic logic [15:0] fold18(input logic [17:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {15'b0, s[17:16]};
      return t[15:0] + {15'b0, t[16]};
   endfunction

endpackage

@@ rtl/core/phpc_front.sv @@
// Front end of the frame header parser: accepts bytes, tracks the frame
// position and header lengths, and turns each byte into a command word.
// Depends on phpc_pkg.
module phpc_front import phpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    queue_full,
   output logic    push,
   output cmd_type push_cmd
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      eth_type_ff, eth_type_in;
   logic [3:0]       ihl_ff, ihl_in;
   logic [15:0]      tlen_ff, tlen_in;

   logic             accept;
   logic             in_range;
   logic             is_ip;
   logic [7:0]       b;
   logic [5:0]       hl;
   logic [POS_W-1:0] l4_start;
   logic [POS_W-1:0] l4_off;
   logic             at_l4;
   logic [15:0]      seg_len;
   byte_op_type      op;

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;
   assign b         = req_data.data_byte;

   always_comb begin
      in_range = pos_ff < POS_W'(MAX_FRAME_BYTES);

      eth_type_in = eth_type_ff;
      if (in_range && (pos_ff == POS_ETH_TYPE_HI || pos_ff == POS_ETH_TYPE_LO)) begin
         eth_type_in = {eth_type_ff[7:0], b};
      end

      is_ip = in_range && (eth_type_in == ETH_TYPE_IPV4) && (pos_ff >= POS_IP_START);

      ihl_in = ihl_ff;
      if (is_ip && pos_ff == POS_IP_START) begin
         ihl_in = b[3:0];
      end
      hl       = {ihl_in, 2'b00};
      l4_start = POS_IP_START + POS_W'(hl);

      tlen_in = tlen_ff;
      if (is_ip && (pos_ff == POS_TLEN_HI || pos_ff == POS_TLEN_LO)) begin
         tlen_in = {tlen_ff[7:0], b};
      end
      seg_len = tlen_in - {10'b0, hl};

      at_l4  = is_ip && (pos_ff >= l4_start);
      l4_off = pos_ff - l4_start;

      op.hdr_add    = is_ip && (pos_ff < l4_start);
      op.pseudo_add = is_ip && (pos_ff >= POS_PSEUDO_FIRST) && (pos_ff <= POS_PSEUDO_LAST);
      op.seg_add    = at_l4 && (CMP_W'(l4_off) < CMP_W'(seg_len));
      op.cap_ttl    = is_ip && (pos_ff == POS_TTL);
      op.cap_proto  = is_ip && (pos_ff == POS_PROTO);
      op.cap_type   = at_l4 && (l4_off == '0);
      op.cap_src    = at_l4 && (l4_off <= L4_OFF_SRC_LO);
      op.cap_dst    = at_l4 && (l4_off == L4_OFF_DST_HI || l4_off == L4_OFF_DST_LO);
      op.cap_flags  = at_l4 && (l4_off == L4_OFF_FLAGS);
      op.cap_arp    = in_range && (eth_type_in == ETH_TYPE_ARP) &&
                      (pos_ff == POS_ARP_OP_HI || pos_ff == POS_ARP_OP_LO);

      pos_in = in_range ? pos_ff + POS_W'(1) : pos_ff;

      push_cmd.data         = b;
      push_cmd.odd          = pos_ff[0];
      push_cmd.op           = op;
      push_cmd.last         = req_data.last_byte;
      push_cmd.ihl          = ihl_in;
      push_cmd.total_length = tlen_in;
      push_cmd.seg_len      = seg_len;
      push_cmd.ip_len_ok    = CMP_W'(pos_in) >= CMP_W'(l4_start);
      push_cmd.seg_len_ok   = (ihl_in >= IHL_MIN) &&
                              (CMP_W'(pos_in) >= CMP_W'(l4_start) + CMP_W'(seg_len));
      if (eth_type_in == ETH_TYPE_IPV4) begin
         push_cmd.frame_kind = FRAME_IPV4;
      end else if (eth_type_in == ETH_TYPE_ARP) begin
         push_cmd.frame_kind = FRAME_ARP;
      end else begin
         push_cmd.frame_kind = FRAME_UNKNOWN;
      end
   end

   assign push = accept;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_byte)) begin
         pos_ff      <= '0;
         eth_type_ff <= '0;
         ihl_ff      <= '0;
         tlen_ff     <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         eth_type_ff <= eth_type_in;
         ihl_ff      <= ihl_in;
         tlen_ff     <= tlen_in;
      end
   end

endmodule

@@ rtl/core/phpc_fifo.sv @@
// Short command queue between the parser front end and back end.
// Depends on phpc_pkg.
module phpc_fifo import phpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type                entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]    count_ff, count_in;

   assign full    = count_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (FIFO_PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/phpc_back.sv @@
// Back end of the frame header parser: runs the checksum sums and field
// captures per command word, snapshots a finished frame and formats the result.
// Depends on phpc_pkg.
module phpc_back import phpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic [15:0] hdr_sum_ff, hdr_sum_in;
   logic [15:0] seg_sum_ff, seg_sum_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [3:0]  flags_ff, flags_in;

   logic        fin_valid_ff, fin_valid_in;
   fin_type     fin_ff, fin_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        fin_free;
   logic        finish;
   logic [15:0] w;
   logic [15:0] seg_mid;
   logic [15:0] tcp_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fin_free = !fin_valid_ff || out_free;
   assign cmd_pop  = cmd_valid && (!cmd.last || fin_free);
   assign finish   = cmd_pop && cmd.last;

   // Per-byte accumulation. The pseudoheader add runs before the segment add
   // when a short header makes both apply to the same byte.
   always_comb begin
      w = cmd.odd ? {8'b0, cmd.data} : {cmd.data, 8'b0};

      hdr_sum_in = cmd.op.hdr_add ? fold17({1'b0, hdr_sum_ff} + {1'b0, w}) : hdr_sum_ff;
      seg_mid    = cmd.op.pseudo_add ? fold17({1'b0, seg_sum_ff} + {1'b0, w}) : seg_sum_ff;
      seg_sum_in = cmd.op.seg_add ? fold17({1'b0, seg_mid} + {1'b0, w}) : seg_mid;

      ttl_in   = cmd.op.cap_ttl   ? cmd.data : ttl_ff;
      proto_in = cmd.op.cap_proto ? cmd.data : proto_ff;

      type_in = type_ff;
      if (cmd.op.cap_type) begin
         type_in = {8'b0, cmd.data};
      end else if (cmd.op.cap_arp) begin
         type_in = {type_ff[7:0], cmd.data};
      end

      src_in   = cmd.op.cap_src ? {src_ff[7:0], cmd.data} : src_ff;
      dst_in   = cmd.op.cap_dst ? {dst_ff[7:0], cmd.data} : dst_ff;
      flags_in = cmd.op.cap_flags ? {cmd.data[4], cmd.data[1], cmd.data[2], cmd.data[0]} :
                 flags_ff;

      fin_in.frame_kind   = cmd.frame_kind;
      fin_in.ihl          = cmd.ihl;
      fin_in.total_length = cmd.total_length;
      fin_in.seg_len      = cmd.seg_len;
      fin_in.ip_len_ok    = cmd.ip_len_ok;
      fin_in.seg_len_ok   = cmd.seg_len_ok;
      fin_in.hdr_sum      = hdr_sum_in;
      fin_in.seg_sum      = seg_sum_in;
      fin_in.ttl          = ttl_in;
      fin_in.proto        = proto_in;
      fin_in.src_port     = src_in;
      fin_in.dst_port     = dst_in;
      fin_in.flags        = flags_in;
      fin_in.type_code    = type_in;

      fin_valid_in = (fin_valid_ff && !out_free) || finish;
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         hdr_sum_ff <= '0;
         seg_sum_ff <= '0;
         ttl_ff     <= '0;
         proto_ff   <= '0;
         type_ff    <= '0;
         src_ff     <= '0;
         dst_ff     <= '0;
         flags_ff   <= '0;
      end else if (cmd_pop) begin
         hdr_sum_ff <= hdr_sum_in;
         seg_sum_ff <= seg_sum_in;
         ttl_ff     <= ttl_in;
         proto_ff   <= proto_in;
         type_ff    <= type_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         flags_ff   <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         fin_ff <= fin_in;
      end
   end

   // Result formatting from the snapshot; fields foreign to the frame stay zero.
   always_comb begin
      tcp_sum     = fold18({2'b0, fin_ff.seg_sum} + {10'b0, fin_ff.proto} +
                           {2'b0, fin_ff.seg_len});
      rsp_data_in = '0;
      if (fin_ff.frame_kind == FRAME_IPV4) begin
         rsp_data_in.frame_kind      = FRAME_IPV4;
         rsp_data_in.ip_header_bytes = {fin_ff.ihl, 2'b00};
         rsp_data_in.ip_pdu_length   = fin_ff.total_length;
         rsp_data_in.time_to_live    = fin_ff.ttl;
         rsp_data_in.ip_checksum_ok  = fin_ff.ip_len_ok && (fin_ff.hdr_sum == SUM_ALL_ONES);
         if (fin_ff.proto == PROTO_ICMP) begin
            rsp_data_in.l4_kind   = L4_ICMP;
            rsp_data_in.type_code = {8'b0, fin_ff.type_code[7:0]};
         end else if (fin_ff.proto == PROTO_UDP) begin
            rsp_data_in.l4_kind     = L4_UDP;
            rsp_data_in.source_port = fin_ff.src_port;
            rsp_data_in.dest_port   = fin_ff.dst_port;
         end else if (fin_ff.proto == PROTO_TCP) begin
            rsp_data_in.l4_kind         = L4_TCP;
            rsp_data_in.source_port     = fin_ff.src_port;
            rsp_data_in.dest_port       = fin_ff.dst_port;
            rsp_data_in.tcp_flag_bits   = fin_ff.flags;
            rsp_data_in.tcp_checksum_ok = fin_ff.seg_len_ok && (tcp_sum == SUM_ALL_ONES);
         end
      end else if (fin_ff.frame_kind == FRAME_ARP) begin
         rsp_data_in.frame_kind = FRAME_ARP;
         rsp_data_in.type_code  = fin_ff.type_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && fin_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/packet_header_parse_checksum.sv @@
// Top level of the Ethernet/ARP/IPv4/ICMP/UDP/TCP header parser with Internet checksum check.
// Depends on phpc_pkg, phpc_front, phpc_fifo and phpc_back.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------------
//   req     | in        | req_valid, req_stall | req_type: one frame byte + last flag
//   rsp     | out       | rsp_valid, rsp_stall | rsp_type: one summary per frame
//
// One byte is taken every cycle while the command queue has room; the back end
// retires one command word per cycle while the queue is not empty, but a frame's
// last word waits while a stalled result fills the output and snapshot registers,
// so the sustained rate is one byte per cycle only while results flow. A frame
// summary goes via the queue, the frame snapshot register and the output register.
// Reset is synchronous and active high; it empties the queue and clears all
// frame state. A stalled result holds in the output register while the snapshot
// stage and the four-word queue keep absorbing bytes.
module packet_header_parse_checksum import phpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   // The front end classifies each byte against the running frame position and
   // header lengths; the back end owns the checksum sums and captured fields.
   logic    queue_full;
   logic    queue_empty;
   logic    queue_push;
   logic    queue_pop;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   phpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (queue_push),
      .push_cmd   (push_cmd)
   );

   // The queue decouples byte intake from a stalled result.
   phpc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   phpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!queue_empty),
      .cmd       (pop_cmd),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

`ifndef SYNTH
   // The front end must never write into a full queue.
   assert property (@(posedge clock) disable iff (reset) queue_push |-> !queue_full)
      else $error("command queue overflow");

   // The back end must never read from an empty queue.
   assert property (@(posedge clock) disable iff (reset) queue_pop |-> !queue_empty)
      else $error("command queue underflow");

   // A layer-4 kind is only reported for an IPv4 frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.l4_kind != L4_NONE) |-> (rsp_data.frame_kind == FRAME_IPV4))
      else $error("layer-4 kind on a non-IPv4 frame");

   // A passing segment checksum is only reported for TCP.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.tcp_checksum_ok) |-> (rsp_data.l4_kind == L4_TCP))
      else $error("segment checksum flag on a non-TCP frame");

   // No result can be presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
